@@ hdl/assert_macros.svh @@
// Assertion macros used by the top level of the frequency-response evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CHK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/bqfr_pkg.sv @@
// Package with types, constants and the arctangent table of the frequency-response evaluator.
`default_nettype none
package bqfr_pkg;

    localparam int ATAN_LEN      = 24;
    localparam int ANG_DIV_STEPS = 52;
    localparam int MAG_DIV_STEPS = 52;
    localparam int MAG_W         = 36;
    localparam int SUM_W         = 36;
    localparam int VEC_W         = 40;
    localparam int ROT_W         = 34;

    localparam logic [29:0] K_Q30 = 30'd652032874;

    localparam logic [2:0] REG_NUM0 = 3'd0;
    localparam logic [2:0] REG_NUM1 = 3'd1;
    localparam logic [2:0] REG_NUM2 = 3'd2;
    localparam logic [2:0] REG_DEN0 = 3'd3;
    localparam logic [2:0] REG_DEN1 = 3'd4;
    localparam logic [2:0] REG_DEN2 = 3'd5;
    localparam logic [2:0] REG_FS   = 3'd6;
    localparam logic [2:0] REG_GAIN = 3'd7;

    typedef struct packed {
        logic                    flip;
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
    } t_rot;

    typedef struct packed {
        logic                    zero;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [31:0]             z;
    } t_vec;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hdl/bqfr_div_cell.sv @@
// One restoring-division cell: brings in one dividend bit and forms one quotient bit.
`default_nettype none
module bqfr_div_cell #(
    parameter int NW = 52,
    parameter int DW = 20,
    parameter int QW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [QW-1:0] i_quo,
    output logic      [NW-1:0] o_num,
    output logic      [DW-1:0] o_den,
    output logic      [DW-1:0] o_rem,
    output logic      [QW-1:0] o_quo
);

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_quo;

    always_comb begin
        w_trial = {i_rem, i_num[NW-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_ge    = (w_trial >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= {i_num[NW-2:0], 1'b0};
            r_den <= i_den;
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_quo <= {i_quo[QW-2:0], w_ge};
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule
`default_nettype wire

@@ hdl/bqfr_rot_cell.sv @@
// One rotation CORDIC cell: turns the vector by one table angle toward the residual angle.
`default_nettype none
module bqfr_rot_cell #(
    parameter int STAGE = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire bqfr_pkg::t_rot i_s,
    output bqfr_pkg::t_rot     o_s
);

    localparam logic signed [bqfr_pkg::ROT_W-1:0] ATAN =
        bqfr_pkg::ROT_W'(bqfr_pkg::atan_turn(STAGE));

    logic signed [bqfr_pkg::ROT_W-1:0] w_x;
    logic signed [bqfr_pkg::ROT_W-1:0] w_y;
    logic signed [bqfr_pkg::ROT_W-1:0] w_z;
    bqfr_pkg::t_rot                    w_n;
    bqfr_pkg::t_rot                    r_s;

    always_comb begin
        w_x      = i_s.x;
        w_y      = i_s.y;
        w_z      = i_s.z;
        w_n.flip = i_s.flip;
        if (w_z >= 0) begin
            w_n.x = w_x - (w_y >>> STAGE);
            w_n.y = w_y + (w_x >>> STAGE);
            w_n.z = w_z - ATAN;
        end else begin
            w_n.x = w_x + (w_y >>> STAGE);
            w_n.y = w_y - (w_x >>> STAGE);
            w_n.z = w_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= w_n;
        end
    end

    assign o_s = r_s;

endmodule
`default_nettype wire

@@ hdl/bqfr_vec_cell.sv @@
// One vectoring CORDIC cell: turns the vector one table angle toward the x axis.
`default_nettype none
module bqfr_vec_cell #(
    parameter int STAGE = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire bqfr_pkg::t_vec i_s,
    output bqfr_pkg::t_vec     o_s
);

    localparam logic [31:0] ATAN = bqfr_pkg::atan_turn(STAGE);

    logic signed [bqfr_pkg::VEC_W-1:0] w_x;
    logic signed [bqfr_pkg::VEC_W-1:0] w_y;
    bqfr_pkg::t_vec                    w_n;
    bqfr_pkg::t_vec                    r_s;

    always_comb begin
        w_x      = i_s.x;
        w_y      = i_s.y;
        w_n.zero = i_s.zero;
        if (w_y >= 0) begin
            w_n.x = w_x + (w_y >>> STAGE);
            w_n.y = w_y - (w_x >>> STAGE);
            w_n.z = i_s.z + ATAN;
        end else begin
            w_n.x = w_x - (w_y >>> STAGE);
            w_n.y = w_y + (w_x >>> STAGE);
            w_n.z = i_s.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= w_n;
        end
    end

    assign o_s = r_s;

endmodule
`default_nettype wire

@@ hdl/biquad_frequency_response.sv @@
// Top level of the biquad frequency-response evaluator.
//
// channel  | direction | tdata (low bit up)             | tuser
// s_axis   | in        | frequency_hz[19:0], pad[23:20] | -
// m_axis   | out       | magnitude[31:0], phase[47:32]  | invalid
// cfg      | in        | i_cfg_addr selects, i_cfg_wdata holds the value
//
// One request per cycle while no result is held at m_axis; the path holds two 52-cell
// division chains, rotation and vectoring CORDIC cell chains, multiply and sum stages.
// Reset clears the valid chain and loads the register defaults.
// A result held at m_axis without tready freezes the whole cell chain;
// s_axis_tready follows that freeze.
`default_nettype none
`include "assert_macros.svh"
module biquad_frequency_response #(
    parameter int NUM_TAPS      = 3,
    parameter int DEN_TAPS      = 3,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // frequency_hz[19:0], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata,   // magnitude[31:0], phase[47:32]
    output logic             m_axis_tuser,   // invalid
    input  wire logic        i_cfg_wen,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata
);

    localparam int NSTG = (CORDIC_STAGES > bqfr_pkg::ATAN_LEN) ? bqfr_pkg::ATAN_LEN
                                                               : CORDIC_STAGES;
    localparam int NT   = (NUM_TAPS > 3) ? 3 : NUM_TAPS;
    localparam int DT   = (DEN_TAPS > 3) ? 3 : DEN_TAPS;
    localparam int ADS  = bqfr_pkg::ANG_DIV_STEPS;
    localparam int MDS  = bqfr_pkg::MAG_DIV_STEPS;
    localparam int MW   = bqfr_pkg::MAG_W;
    localparam int SW   = bqfr_pkg::SUM_W;
    localparam int VW   = bqfr_pkg::VEC_W;
    localparam int RW   = bqfr_pkg::ROT_W;
    localparam int LAT  = 2 * NSTG + ADS + MDS + 6;

    // configuration
    logic signed [31:0] r_num [3];
    logic signed [31:0] r_den [3];
    logic [19:0]        r_fs;
    logic [31:0]        r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num[0] <= 32'sd16777216;
            r_num[1] <= 32'sd0;
            r_num[2] <= 32'sd0;
            r_den[0] <= 32'sd16777216;
            r_den[1] <= 32'sd0;
            r_den[2] <= 32'sd0;
            r_fs     <= 20'd44100;
            r_gain   <= 32'd16777216;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                bqfr_pkg::REG_NUM0: r_num[0] <= i_cfg_wdata;
                bqfr_pkg::REG_NUM1: r_num[1] <= i_cfg_wdata;
                bqfr_pkg::REG_NUM2: r_num[2] <= i_cfg_wdata;
                bqfr_pkg::REG_DEN0: r_den[0] <= i_cfg_wdata;
                bqfr_pkg::REG_DEN1: r_den[1] <= i_cfg_wdata;
                bqfr_pkg::REG_DEN2: r_den[2] <= i_cfg_wdata;
                bqfr_pkg::REG_FS:   r_fs     <= i_cfg_wdata[19:0];
                bqfr_pkg::REG_GAIN: r_gain   <= i_cfg_wdata;
                default:            r_gain   <= r_gain;
            endcase
        end
    end

    // flow control
    logic           w_en;
    logic [LAT-1:0] r_vld;

    assign w_en          = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // angle: turn = frac(f * 2^32 / fs)
    logic [51:0] w_an_num [ADS+1];
    logic [19:0] w_an_den [ADS+1];
    logic [19:0] w_an_rem [ADS+1];
    logic [31:0] w_an_quo [ADS+1];

    assign w_an_num[0] = {s_axis_tdata[19:0], 32'd0};
    assign w_an_den[0] = (r_fs == 20'd0) ? 20'd1 : r_fs;
    assign w_an_rem[0] = '0;
    assign w_an_quo[0] = '0;

    for (genvar gi = 0; gi < ADS; gi++) begin : g_adiv
        bqfr_div_cell #(.NW(52), .DW(20), .QW(32)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_an_num[gi]),
            .i_den (w_an_den[gi]),
            .i_rem (w_an_rem[gi]),
            .i_quo (w_an_quo[gi]),
            .o_num (w_an_num[gi+1]),
            .o_den (w_an_den[gi+1]),
            .o_rem (w_an_rem[gi+1]),
            .o_quo (w_an_quo[gi+1])
        );
    end

    // cos and sin of 0, w, 2w
    logic [31:0]        w_ang [3];
    bqfr_pkg::t_rot     w_rot [3][NSTG+1];
    logic signed [31:0] w_cos [3];
    logic signed [31:0] w_sin [3];

    assign w_ang[0] = 32'd0;
    assign w_ang[1] = w_an_quo[ADS];
    assign w_ang[2] = {w_an_quo[ADS][30:0], 1'b0};

    for (genvar gk = 0; gk < 3; gk++) begin : g_rot
        logic signed [RW-1:0] w_za;
        logic signed [RW-1:0] w_xe;
        logic signed [RW-1:0] w_ye;

        always_comb begin
            w_za                = RW'(signed'(w_ang[gk]));
            w_rot[gk][0].x      = RW'(signed'({2'b00, bqfr_pkg::K_Q30}));
            w_rot[gk][0].y      = '0;
            if (w_za > RW'(signed'(33'h040000000))) begin
                w_rot[gk][0].z    = w_za - RW'(signed'(33'h080000000));
                w_rot[gk][0].flip = 1'b1;
            end else if (w_za < -RW'(signed'(33'h040000000))) begin
                w_rot[gk][0].z    = w_za + RW'(signed'(33'h080000000));
                w_rot[gk][0].flip = 1'b1;
            end else begin
                w_rot[gk][0].z    = w_za;
                w_rot[gk][0].flip = 1'b0;
            end
        end

        for (genvar gs = 0; gs < NSTG; gs++) begin : g_cell
            bqfr_rot_cell #(.STAGE(gs)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_s   (w_rot[gk][gs]),
                .o_s   (w_rot[gk][gs+1])
            );
        end

        always_comb begin
            w_xe = w_rot[gk][NSTG].x;
            w_ye = w_rot[gk][NSTG].y;
            if (w_rot[gk][NSTG].flip) begin
                w_xe = -w_xe;
                w_ye = -w_ye;
            end
            w_cos[gk] = w_xe[31:0];
            w_sin[gk] = w_ye[31:0];
        end
    end

    // coefficient products
    logic signed [63:0] r_pnc [3];
    logic signed [63:0] r_pns [3];
    logic signed [63:0] r_pdc [3];
    logic signed [63:0] r_pds [3];
    logic signed [31:0] w_bn  [3];
    logic signed [31:0] w_ad  [3];

    for (genvar gk = 0; gk < 3; gk++) begin : g_prod
        assign w_bn[gk] = (gk < NT) ? r_num[gk] : 32'sd0;
        assign w_ad[gk] = (gk < DT) ? r_den[gk] : 32'sd0;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pnc[gk] <= w_bn[gk] * w_cos[gk];
                r_pns[gk] <= w_bn[gk] * w_sin[gk];
                r_pdc[gk] <= w_ad[gk] * w_cos[gk];
                r_pds[gk] <= w_ad[gk] * w_sin[gk];
            end
        end
    end

    // sums, floored to Q.24
    logic signed [65:0]   w_snr;
    logic signed [65:0]   w_sni;
    logic signed [65:0]   w_sdr;
    logic signed [65:0]   w_sdi;
    logic signed [SW-1:0] r_nre;
    logic signed [SW-1:0] r_nim;
    logic signed [SW-1:0] r_dre;
    logic signed [SW-1:0] r_dim;

    always_comb begin
        w_snr = 66'(r_pnc[0]) + 66'(r_pnc[1]) + 66'(r_pnc[2]);
        w_sni = -(66'(r_pns[0]) + 66'(r_pns[1]) + 66'(r_pns[2]));
        w_sdr = 66'(r_pdc[0]) + 66'(r_pdc[1]) + 66'(r_pdc[2]);
        w_sdi = -(66'(r_pds[0]) + 66'(r_pds[1]) + 66'(r_pds[2]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nre <= w_snr[65:30];
            r_nim <= w_sni[65:30];
            r_dre <= w_sdr[65:30];
            r_dim <= w_sdi[65:30];
        end
    end

    // magnitude and angle of N and D
    bqfr_pkg::t_vec w_vn [NSTG+1];
    bqfr_pkg::t_vec w_vd [NSTG+1];

    always_comb begin
        w_vn[0].zero = (r_nre == '0) && (r_nim == '0);
        w_vd[0].zero = (r_dre == '0) && (r_dim == '0);
        if (r_nre < 0) begin
            w_vn[0].x = -VW'(r_nre);
            w_vn[0].y = -VW'(r_nim);
            w_vn[0].z = 32'h80000000;
        end else begin
            w_vn[0].x = VW'(r_nre);
            w_vn[0].y = VW'(r_nim);
            w_vn[0].z = 32'h00000000;
        end
        if (r_dre < 0) begin
            w_vd[0].x = -VW'(r_dre);
            w_vd[0].y = -VW'(r_dim);
            w_vd[0].z = 32'h80000000;
        end else begin
            w_vd[0].x = VW'(r_dre);
            w_vd[0].y = VW'(r_dim);
            w_vd[0].z = 32'h00000000;
        end
    end

    for (genvar gs = 0; gs < NSTG; gs++) begin : g_vec
        bqfr_vec_cell #(.STAGE(gs)) u_num (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_s   (w_vn[gs]),
            .o_s   (w_vn[gs+1])
        );
        bqfr_vec_cell #(.STAGE(gs)) u_den (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_s   (w_vd[gs]),
            .o_s   (w_vd[gs+1])
        );
    end

    // scale by K in two partial products; form the phase
    logic [49:0] r_a_nh;
    logic [49:0] r_a_nl;
    logic [49:0] r_a_dh;
    logic [49:0] r_a_dl;
    logic        r_a_zn;
    logic        r_a_zd;
    logic [15:0] r_a_phase;
    logic [31:0] w_ang_n;
    logic [31:0] w_ang_d;
    logic [31:0] w_dphi;
    logic [19:0] w_xnh;
    logic [19:0] w_xdh;

    always_comb begin
        w_ang_n = w_vn[NSTG].zero ? 32'd0 : w_vn[NSTG].z;
        w_ang_d = w_vd[NSTG].zero ? 32'd0 : w_vd[NSTG].z;
        w_dphi  = w_ang_n - w_ang_d;
        w_xnh   = w_vn[NSTG].x[39:20];
        w_xdh   = w_vd[NSTG].x[39:20];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_nh    <= 50'(w_xnh) * 50'(bqfr_pkg::K_Q30);
            r_a_nl    <= 50'(w_vn[NSTG].x[19:0]) * 50'(bqfr_pkg::K_Q30);
            r_a_dh    <= 50'(w_xdh) * 50'(bqfr_pkg::K_Q30);
            r_a_dl    <= 50'(w_vd[NSTG].x[19:0]) * 50'(bqfr_pkg::K_Q30);
            r_a_zn    <= w_vn[NSTG].zero;
            r_a_zd    <= w_vd[NSTG].zero;
            r_a_phase <= (w_dphi == 32'h80000000) ? 16'h7FFF : w_dphi[31:16];
        end
    end

    logic [69:0]   w_mn_full;
    logic [69:0]   w_md_full;
    logic [MW-1:0] r_b_magn;
    logic [MW-1:0] r_b_magd;
    logic          r_b_inv;
    logic [15:0]   r_b_phase;
    logic [MW-1:0] w_magd;

    always_comb begin
        w_mn_full = {r_a_nh, 20'd0} + 70'(r_a_nl);
        w_md_full = {r_a_dh, 20'd0} + 70'(r_a_dl);
        w_magd    = r_a_zd ? '0 : w_md_full[65:30];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_magn  <= r_a_zn ? '0 : w_mn_full[65:30];
            r_b_magd  <= w_magd;
            r_b_inv   <= (w_magd == '0);
            r_b_phase <= r_a_phase;
        end
    end

    // ratio |N| * 2^16 / |D|
    logic [51:0]   w_md_num [MDS+1];
    logic [MW-1:0] w_md_den [MDS+1];
    logic [MW-1:0] w_md_rem [MDS+1];
    logic [51:0]   w_md_quo [MDS+1];
    logic [16:0]   r_sb     [MDS];

    assign w_md_num[0] = {r_b_magn, 16'd0};
    assign w_md_den[0] = r_b_magd;
    assign w_md_rem[0] = '0;
    assign w_md_quo[0] = '0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb[0] <= {r_b_inv, r_b_phase};
        end
    end

    for (genvar gi = 0; gi < MDS; gi++) begin : g_mdiv
        bqfr_div_cell #(.NW(52), .DW(MW), .QW(52)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_md_num[gi]),
            .i_den (w_md_den[gi]),
            .i_rem (w_md_rem[gi]),
            .i_quo (w_md_quo[gi]),
            .o_num (w_md_num[gi+1]),
            .o_den (w_md_den[gi+1]),
            .o_rem (w_md_rem[gi+1]),
            .o_quo (w_md_quo[gi+1])
        );
        if (gi > 0) begin : g_sb
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sb[gi] <= r_sb[gi-1];
                end
            end
        end
    end

    // gain in two partial products, then saturate
    logic [57:0] r_gh;
    logic [57:0] r_gl;
    logic [16:0] r_g_sb;
    logic [83:0] w_gfull;
    logic [31:0] w_res;
    logic [31:0] r_o_mag;
    logic [15:0] r_o_phase;
    logic        r_o_inv;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gh   <= 58'(w_md_quo[MDS][51:26]) * 58'(r_gain);
            r_gl   <= 58'(w_md_quo[MDS][25:0]) * 58'(r_gain);
            r_g_sb <= r_sb[MDS-1];
        end
    end

    always_comb begin
        w_gfull = {r_gh, 26'd0} + 84'(r_gl);
        w_res   = (|w_gfull[83:56]) ? 32'hFFFFFFFF : w_gfull[55:24];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_inv   <= r_g_sb[16];
            r_o_mag   <= r_g_sb[16] ? 32'd0 : w_res;
            r_o_phase <= r_g_sb[16] ? 16'd0 : r_g_sb[15:0];
        end
    end

    assign m_axis_tdata = {r_o_phase, r_o_mag};
    assign m_axis_tuser = r_o_inv;

    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result after reset")
    `ASSERT_CHK(a_inv_zero, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 48'd0), "invalid result not cleared")
    `ASSERT_CHK(a_gain_zero, i_clk, i_rst_n, (m_axis_tvalid && r_gain == 32'd0) |-> (m_axis_tdata[31:0] == 32'd0), "nonzero magnitude at zero gain")

endmodule
`default_nettype wire

@@ bench/bqfr_checker.sv @@
// Checker that predicts frequency-response results and compares them at the output channel.
`timescale 1ns / 1ps
module bqfr_checker #(
    parameter int NUM_TAPS      = 3,
    parameter int DEN_TAPS      = 3,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [47:0] m_axis_tdata,
    input  wire logic        m_axis_tuser,
    input  wire logic        i_cfg_wen,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [31:0] mag;
        logic [15:0] phase;
        logic        invalid;
    } t_resp;

    localparam longint K_MUL = 652032874;
    localparam longint HALF  = 64'h80000000;
    localparam longint QUART = 64'h40000000;

    logic [31:0] coef_q [8];
    t_resp       resp_q [$];

    function automatic int n_stages();
        return (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
    endfunction

    function automatic longint asr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint tbl(int i);
        logic [31:0] v;
        case (i)
            0: v = 32'h20000000; 1: v = 32'h12E4051E; 2: v = 32'h09FB385B;
            3: v = 32'h051111D4; 4: v = 32'h028B0D43; 5: v = 32'h0145D7E1;
            6: v = 32'h00A2F61E; 7: v = 32'h00517C55; 8: v = 32'h0028BE53;
            9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
            12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
            15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
            18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
            21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return longint'({32'h0, v});
    endfunction

    function automatic void rotate_angle(input logic [31:0] a, output longint c,
                                         output longint s);
        longint z, x, y, nx;
        bit flip;
        z = longint'($signed(a));
        x = K_MUL;
        y = 0;
        flip = 0;
        if (z > QUART) begin
            z -= HALF; flip = 1;
        end else if (z < -QUART) begin
            z += HALF; flip = 1;
        end
        for (int i = 0; i < n_stages(); i++) begin
            if (z >= 0) begin
                nx = x - asr_floor(y, i); y = y + asr_floor(x, i); z -= tbl(i);
            end else begin
                nx = x + asr_floor(y, i); y = y - asr_floor(x, i); z += tbl(i);
            end
            x = nx;
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic void vector_polar(input longint xi, input longint yi,
                                         output longint unsigned mag,
                                         output logic [31:0] ang);
        longint x, y, z, nx;
        x = xi; y = yi; z = 0;
        if (x == 0 && y == 0) begin
            mag = 0; ang = 0;
            return;
        end
        if (x < 0) begin
            x = -x; y = -y; z = HALF;
        end
        for (int i = 0; i < n_stages(); i++) begin
            if (y >= 0) begin
                nx = x + asr_floor(y, i); y = y - asr_floor(x, i); z += tbl(i);
            end else begin
                nx = x - asr_floor(y, i); y = y + asr_floor(x, i); z -= tbl(i);
            end
            x = nx;
        end
        mag = (longint'(x) * K_MUL) >> 30;
        ang = z[31:0];
    endfunction

    function automatic void sum_taps(input int base, input int taps, input longint cs[3],
                                     input longint sn[3], output longint re,
                                     output longint im);
        longint r, m, b;
        int t;
        r = 0; m = 0;
        t = (taps > 3) ? 3 : taps;
        for (int k = 0; k < t; k++) begin
            b = longint'($signed(coef_q[base+k]));
            r += b * cs[k];
            m -= b * sn[k];
        end
        re = r >>> 30;
        im = m >>> 30;
    endfunction

    function automatic t_resp predict_response(logic [19:0] f);
        longint unsigned fs, turn, magn, magd, r, g, res;
        longint cs[3], sn[3], nr, ni, dr, di, c, s;
        logic [31:0] angn, angd, d;
        t_resp o;
        fs = coef_q[bqfr_pkg::REG_FS][19:0];
        if (fs == 0) fs = 1;
        turn = ((longint'(f) % fs) << 32) / fs;
        for (int k = 0; k < 3; k++) begin
            rotate_angle(32'(k * turn), c, s);
            cs[k] = c; sn[k] = s;
        end
        sum_taps(0, NUM_TAPS, cs, sn, nr, ni);
        sum_taps(3, DEN_TAPS, cs, sn, dr, di);
        vector_polar(nr, ni, magn, angn);
        vector_polar(dr, di, magd, angd);
        if (magd == 0) begin
            o.mag = 0; o.phase = 0; o.invalid = 1;
            return o;
        end
        r = (magn << 16) / magd;
        g = coef_q[bqfr_pkg::REG_GAIN];
        if (g == 0) res = 0;
        else if (r > 64'hFFFFFFFFFFFFFFFF / g) res = 64'hFFFFFFFF;
        else begin
            res = (r * g) >> 24;
            if (res > 64'hFFFFFFFF) res = 64'hFFFFFFFF;
        end
        d = angn - angd;
        o.mag = res[31:0];
        o.phase = (d == 32'h80000000) ? 16'h7FFF : d[31:16];
        o.invalid = 0;
        return o;
    endfunction

    assign o_pending = resp_q.size();

    always_ff @(posedge i_clk) begin
        t_resp got, want;
        if (!i_rst_n) begin
            coef_q[bqfr_pkg::REG_NUM0] <= 32'h01000000;
            coef_q[bqfr_pkg::REG_NUM1] <= 0;
            coef_q[bqfr_pkg::REG_NUM2] <= 0;
            coef_q[bqfr_pkg::REG_DEN0] <= 32'h01000000;
            coef_q[bqfr_pkg::REG_DEN1] <= 0;
            coef_q[bqfr_pkg::REG_DEN2] <= 0;
            coef_q[bqfr_pkg::REG_FS]   <= 32'd44100;
            coef_q[bqfr_pkg::REG_GAIN] <= 32'h01000000;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_wen)
                coef_q[i_cfg_addr] <= (i_cfg_addr == bqfr_pkg::REG_FS)
                                      ? {12'h0, i_cfg_wdata[19:0]} : i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                resp_q.push_back(predict_response(s_axis_tdata[19:0]));
            if (m_axis_tvalid && m_axis_tready) begin
                got.mag = m_axis_tdata[31:0];
                got.phase = m_axis_tdata[47:32];
                got.invalid = m_axis_tuser;
                if (resp_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = resp_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch mag exp %h got %h phase exp %h got %h inv exp %b got %b",
                                 $time, want.mag, got.mag, want.phase, got.phase,
                                 want.invalid, got.invalid);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ bench/biquad_frequency_response_tb.sv @@
// Testbench top that drives frequency requests and configuration and gives the verdict.
`timescale 1ns / 1ps
module biquad_frequency_response_tb;

    localparam int LATENCY = 2 * 16 + 110;
    localparam longint LIMIT = 2000000;

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_wen;
    logic [2:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    int          fail_count, pending;
    longint      cycle_count;
    bit          calm, hold_long;

    biquad_frequency_response dut (.*);

    bqfr_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_wen(i_cfg_wen), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off, none when calm.
    initial begin
        m_axis_tready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_long) begin
                m_axis_tready <= 0;
                repeat (600) @(posedge i_clk);
                hold_long = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_wen <= 1; i_cfg_addr <= idx; i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wen <= 0;
        @(posedge i_clk);
    endtask

    task automatic send_freq(input logic [19:0] f);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {4'h0, f};
        @(posedge i_clk iff s_axis_tready);
    endtask

    task automatic drain_idle();
        s_axis_tvalid <= 0;
        @(posedge i_clk iff pending == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    task automatic random_coefs(input bit extreme);
        for (int r = 0; r < 6; r++)
            write_reg(3'(r), extreme ? (($urandom_range(0, 1)) ? 32'h7FFFFFFF : 32'h80000000)
                                     : $signed($urandom_range(0, 32'h04000000)) - 32'sh02000000);
        write_reg(bqfr_pkg::REG_FS, extreme ? $urandom_range(1, 3) : $urandom_range(1000, 96000));
        write_reg(bqfr_pkg::REG_GAIN, extreme ? 32'hFFFFFFFF : $urandom_range(0, 32'h04000000));
    endtask

    initial begin
        logic [19:0] dir_f[12];
        calm = 0; hold_long = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0;
        i_cfg_wen = 0; i_cfg_addr = 0; i_cfg_wdata = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        dir_f = '{0, 1, 11025, 22050, 22049, 44099, 44100, 44101, 88200, 1048575,
                  20'h55555, 20'hAAAAA};
        foreach (dir_f[i]) send_freq(dir_f[i]);
        drain_idle();

        // zero denominator
        write_reg(bqfr_pkg::REG_DEN0, 0);
        send_freq(1000);
        send_freq(0);
        drain_idle();

        // notch-ish numerator 1 + z^-1 hits zero at Nyquist; zero sample rate
        write_reg(bqfr_pkg::REG_DEN0, 32'h01000000);
        write_reg(bqfr_pkg::REG_NUM1, 32'h01000000);
        write_reg(bqfr_pkg::REG_FS, 0);
        send_freq(0); send_freq(5);
        drain_idle();
        write_reg(bqfr_pkg::REG_FS, 2);
        send_freq(1); send_freq(2); send_freq(3);
        drain_idle();

        write_reg(bqfr_pkg::REG_FS, 1048575);
        write_reg(bqfr_pkg::REG_GAIN, 0);
        send_freq(1048574); send_freq(524288);
        drain_idle();

        for (int phase = 0; phase < 8; phase++) begin
            random_coefs(phase == 3 || phase == 6);
            if (phase == 2) hold_long = 1;
            if (phase == 7) calm = 1;
            for (int n = 0; n < 80; n++)
                send_freq((n % 4 == 0) ? 20'($urandom()) : 20'($urandom_range(0, 100000)));
            drain_idle();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
